>>> hdl/prb_pkg.sv
// Package for the pixel range and bearing block: field widths, transaction
// structs, pipeline stage record and the CORDIC arctangent table.
// No dependencies.
`timescale 1ns / 1ps

package prb_pkg;

  // Fixed field widths
  localparam int COORD_BITS = 12;
  localparam int CFG_BITS   = 13;
  localparam int RANGE_BITS = 17;
  localparam int ANGLE_BITS = 16;

  // Offset magnitude width: covers floor(width/2) - x and height - y
  localparam int MAG_BITS = (CFG_BITS > COORD_BITS) ? CFG_BITS : COORD_BITS;

  // Square root operand: (dx^2 + dy^2) * 256, padded to an even width
  localparam int SQ_BITS   = 2 * MAG_BITS + 1;
  localparam int RAD_BITS  = 2 * MAG_BITS + 10;
  localparam int ROOT_BITS = RAD_BITS / 2;
  localparam int REM_BITS  = ROOT_BITS + 2;

  // CORDIC datapath: offsets scaled by 2^16, plus gain headroom and sign
  localparam int CORD_BITS = MAG_BITS + 19;
  localparam int ANG_BITS  = 24;
  localparam int TABLE_LEN = 24;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int RANGE_MAX     = 2 ** RANGE_BITS - 1;
  localparam int BEARING_LIMIT = 23040;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMG_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMG_HEIGHT = 1'b1;

  localparam logic [CFG_BITS-1:0] IMG_WIDTH_RST  = 13'd640;
  localparam logic [CFG_BITS-1:0] IMG_HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic [COORD_BITS-1:0] x_pixel;
    logic [COORD_BITS-1:0] y_pixel;
  } prb_in_t;

  typedef struct packed {
    logic [RANGE_BITS-1:0]        range_fixed;
    logic signed [ANGLE_BITS-1:0] bearing_degrees;
    logic                         zero_range;
  } prb_out_t;

  typedef struct packed {
    logic dx_neg;
    logic on_axis;   // dx == 0: bearing is exactly zero
    logic zero;      // point equals the reference
  } prb_flags_t;

  typedef struct packed {
    logic signed [CORD_BITS-1:0] cx;
    logic signed [CORD_BITS-1:0] cy;
    logic signed [ANG_BITS-1:0]  cz;
    logic [RAD_BITS-1:0]         rad;
    logic [ROOT_BITS-1:0]        root;
    logic [REM_BITS-1:0]         rem;
    prb_flags_t                  flags;
  } prb_iter_t;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic signed [ANG_BITS-1:0] atan_q16(input int unsigned i);
    logic signed [ANG_BITS-1:0] v;
    case (i)
      0:  v = 24'sd2949120;
      1:  v = 24'sd1740967;
      2:  v = 24'sd919879;
      3:  v = 24'sd466945;
      4:  v = 24'sd234379;
      5:  v = 24'sd117304;
      6:  v = 24'sd58666;
      7:  v = 24'sd29335;
      8:  v = 24'sd14668;
      9:  v = 24'sd7334;
      10: v = 24'sd3667;
      11: v = 24'sd1833;
      12: v = 24'sd917;
      13: v = 24'sd458;
      14: v = 24'sd229;
      15: v = 24'sd115;
      16: v = 24'sd57;
      17: v = 24'sd29;
      18: v = 24'sd14;
      19: v = 24'sd7;
      20: v = 24'sd4;
      21: v = 24'sd2;
      22: v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/prb_iter_stage.sv
// One registered iteration of the pipeline: one square root digit and one
// CORDIC vectoring rotation, each if in range. Depends on prb_pkg.
`timescale 1ns / 1ps

module prb_iter_stage #(
  parameter int STAGE         = 0,
  parameter int CORDIC_STAGES = prb_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  prb_pkg::prb_iter_t in_data,
  output logic               out_valid,
  output prb_pkg::prb_iter_t out_data
);
  import prb_pkg::*;

  prb_iter_t                   data_next;
  logic [REM_BITS+1:0]         rem_sh;
  logic [REM_BITS+1:0]         trial;
  logic signed [CORD_BITS-1:0] xs;
  logic signed [CORD_BITS-1:0] ys;

  always_comb begin
    data_next = in_data;
    rem_sh    = {in_data.rem, in_data.rad[RAD_BITS-1 -: 2]};
    trial     = {2'b00, in_data.root, 2'b01};
    xs        = in_data.cx >>> STAGE;
    ys        = in_data.cy >>> STAGE;

    // restoring square root, one result bit
    if (STAGE < ROOT_BITS) begin
      data_next.rad = {in_data.rad[RAD_BITS-3:0], 2'b00};
      if (rem_sh >= trial) begin
        data_next.rem  = REM_BITS'(rem_sh - trial);
        data_next.root = {in_data.root[ROOT_BITS-2:0], 1'b1};
      end else begin
        data_next.rem  = REM_BITS'(rem_sh);
        data_next.root = {in_data.root[ROOT_BITS-2:0], 1'b0};
      end
    end

    // rotate toward the vertical axis
    if (STAGE < CORDIC_STAGES) begin
      if (in_data.cy > 0) begin
        data_next.cx = in_data.cx + ys;
        data_next.cy = in_data.cy - xs;
        data_next.cz = in_data.cz + atan_q16(STAGE);
      end else begin
        data_next.cx = in_data.cx - ys;
        data_next.cy = in_data.cy + xs;
        data_next.cz = in_data.cz - atan_q16(STAGE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

>>> hdl/pixel_range_and_bearing_top.sv
// Top level of the pixel range and bearing block: configuration registers,
// offset and square stages, iteration pipeline, rounding and output.
// Depends on prb_pkg and prb_iter_stage.
`timescale 1ns / 1ps

// Converts an object's pixel position (x_pixel, y_pixel) into range and
// bearing from the bottom-center of the frame, column floor(width/2) and
// row height. range_fixed is the saturated distance rounded to 1/16 pixel;
// bearing_degrees is atan2(dx, |dy|) in degrees with 8 fraction bits,
// positive when the object lies left of center; zero_range flags a point
// on the reference, with range and bearing both zero. A transaction is
// accepted on any cycle with start high; busy is never raised, so a new
// transaction can be issued every cycle. Each result appears for exactly
// one cycle with done high, in issue order, after the offset, square and
// start registers, the iteration pipeline and the output register. The
// iteration pipeline takes one square root digit per stage for 18 digits
// and one CORDIC rotation per stage for CORDIC_STAGES rotations. There
// is no back-pressure: the receiver must take every result as it is shown.
// img_width and img_height are written through cfg_we / cfg_index /
// cfg_data and should only change while no transaction is in flight.

module pixel_range_and_bearing_top #(
  parameter int CORDIC_STAGES = prb_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // command channel
  input  logic                               start,
  output logic                               busy,
  input  prb_pkg::prb_in_t                   item,
  // result channel
  output logic                               done,
  output prb_pkg::prb_out_t                  result,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [prb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [prb_pkg::CFG_BITS-1:0]       cfg_data
);
  import prb_pkg::*;

  // iteration stages: enough for every root digit and every rotation
  localparam int ITER_STAGES = (ROOT_BITS > CORDIC_STAGES) ? ROOT_BITS : CORDIC_STAGES;
  localparam int LATENCY     = ITER_STAGES + 4;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_BITS-1:0] img_width;
  logic [CFG_BITS-1:0] img_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= IMG_WIDTH_RST;
      img_height <= IMG_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMG_WIDTH:  img_width  <= cfg_data;
        REG_IMG_HEIGHT: img_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // no stall anywhere in the pipeline
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------
  // Stage 0: signed offsets and their magnitudes
  // ---------------------------------------------------------------------
  logic signed [MAG_BITS:0] dx;
  logic signed [MAG_BITS:0] dy;
  logic [MAG_BITS-1:0]      adx_next;
  logic [MAG_BITS-1:0]      ady_next;

  always_comb begin
    dx = $signed((MAG_BITS+1)'(img_width[CFG_BITS-1:1]))
       - $signed((MAG_BITS+1)'(item.x_pixel));
    dy = $signed((MAG_BITS+1)'(img_height)) - $signed((MAG_BITS+1)'(item.y_pixel));
    adx_next = dx[MAG_BITS] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
    ady_next = dy[MAG_BITS] ? MAG_BITS'(-dy) : MAG_BITS'(dy);
  end

  logic                s0_valid;
  logic [MAG_BITS-1:0] s0_adx;
  logic [MAG_BITS-1:0] s0_ady;
  prb_flags_t          s0_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_adx           <= adx_next;
    s0_ady           <= ady_next;
    s0_flags.dx_neg  <= dx[MAG_BITS];
    s0_flags.on_axis <= (adx_next == '0);
    s0_flags.zero    <= (adx_next == '0) && (ady_next == '0);
  end

  // ---------------------------------------------------------------------
  // Stage 1: squares (one multiplier each)
  // ---------------------------------------------------------------------
  logic                  s1_valid;
  logic [2*MAG_BITS-1:0] s1_sqx;
  logic [2*MAG_BITS-1:0] s1_sqy;
  logic [MAG_BITS-1:0]   s1_adx;
  logic [MAG_BITS-1:0]   s1_ady;
  prb_flags_t            s1_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_sqx   <= s0_adx * s0_adx;
    s1_sqy   <= s0_ady * s0_ady;
    s1_adx   <= s0_adx;
    s1_ady   <= s0_ady;
    s1_flags <= s0_flags;
  end

  // ---------------------------------------------------------------------
  // Stage 2: radicand and CORDIC start vector (vertical offset on x)
  // ---------------------------------------------------------------------
  logic [SQ_BITS-1:0] sq_sum;
  prb_iter_t          iter_start;

  always_comb begin
    sq_sum           = SQ_BITS'(s1_sqx) + SQ_BITS'(s1_sqy);
    iter_start.rad   = RAD_BITS'({sq_sum, 8'h00});
    iter_start.root  = '0;
    iter_start.rem   = '0;
    iter_start.cx    = $signed(CORD_BITS'({s1_ady, 16'h0000}));
    iter_start.cy    = $signed(CORD_BITS'({s1_adx, 16'h0000}));
    iter_start.cz    = '0;
    iter_start.flags = s1_flags;
  end

  logic      stage_valid [ITER_STAGES+1];
  prb_iter_t stage_data  [ITER_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid[0] <= 1'b0;
    end else begin
      stage_valid[0] <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    stage_data[0] <= iter_start;
  end

  // ---------------------------------------------------------------------
  // Iteration pipeline
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < ITER_STAGES; k++) begin : g_iter
    prb_iter_stage #(
      .STAGE         (k),
      .CORDIC_STAGES (CORDIC_STAGES)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[k]),
      .in_data   (stage_data[k]),
      .out_valid (stage_valid[k+1]),
      .out_data  (stage_data[k+1])
    );
  end

  // ---------------------------------------------------------------------
  // Output stage: round the root to nearest, round the angle to 8
  // fraction bits, clamp and apply the side of center
  // ---------------------------------------------------------------------
  prb_iter_t                   fin;
  logic [ROOT_BITS:0]          root_rnd;
  logic signed [ANG_BITS-1:0]  ang_rnd;
  logic signed [ANG_BITS-1:0]  ang_clamp;
  logic [ANGLE_BITS-1:0]       ang_mag;
  prb_out_t                    result_next;

  always_comb begin
    fin      = stage_data[ITER_STAGES];
    root_rnd = (ROOT_BITS+1)'(fin.root)
             + (ROOT_BITS+1)'(fin.rem > REM_BITS'(fin.root));
    ang_rnd  = (fin.cz + ANG_BITS'(128)) >>> 8;

    if (ang_rnd < 0) begin
      ang_clamp = '0;
    end else if (ang_rnd > ANG_BITS'(BEARING_LIMIT)) begin
      ang_clamp = ANG_BITS'(BEARING_LIMIT);
    end else begin
      ang_clamp = ang_rnd;
    end
    ang_mag = ang_clamp[ANGLE_BITS-1:0];

    if (root_rnd > (ROOT_BITS+1)'(RANGE_MAX)) begin
      result_next.range_fixed = RANGE_BITS'(RANGE_MAX);
    end else begin
      result_next.range_fixed = root_rnd[RANGE_BITS-1:0];
    end

    // on the vertical axis (zero range included) the bearing is exactly 0
    if (fin.flags.on_axis) begin
      result_next.bearing_degrees = '0;
    end else if (fin.flags.dx_neg) begin
      result_next.bearing_degrees = $signed(-ang_mag);
    end else begin
      result_next.bearing_degrees = $signed(ang_mag);
    end
    result_next.zero_range = fin.flags.zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_valid[ITER_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // every accepted transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted transaction did not produce a result on time");

  // no result without a matching accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without a matching transaction");

  // a point on the reference gives zero range and zero bearing
  a_zero_point: assert property (@(posedge clk) disable iff (rst)
    (done && result.zero_range) |->
      (result.range_fixed == '0 && result.bearing_degrees == '0))
    else $error("zero range result with nonzero range or bearing");

  // bearing stays within +/- 90 degrees
  a_bearing_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.bearing_degrees <= 16'sd23040 &&
              result.bearing_degrees >= -16'sd23040))
    else $error("bearing outside +/- 90 degrees");

endmodule

>>> sim/prb_polar_checker.sv
// Checker for the pixel range and bearing block: follows the command, result
// and configuration ports, predicts each result and compares it field by field.
// Depends on prb_pkg.
`timescale 1ns / 1ps

module prb_polar_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  prb_pkg::prb_in_t                   item,
  input  logic                               done,
  input  prb_pkg::prb_out_t                  result,
  input  logic                               cfg_we,
  input  logic [prb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [prb_pkg::CFG_BITS-1:0]       cfg_data,
  output int unsigned                        pending,
  output int unsigned                        checked,
  output int unsigned                        err_count
);
  import prb_pkg::*;

  localparam int STAGES = CORDIC_STAGES_DEF;

  int unsigned n_issued = 0;
  int unsigned n_checked = 0;
  int unsigned n_err = 0;

  assign pending   = n_issued - n_checked;
  assign checked   = n_checked;
  assign err_count = n_err;

  // Shadow copy of the frame registers
  logic [CFG_BITS-1:0] frame_w = IMG_WIDTH_RST;
  logic [CFG_BITS-1:0] frame_h = IMG_HEIGHT_RST;

  prb_out_t polar_q[$];

  // atan(2^-i) in degrees, Q16
  function automatic longint atan_step_q16(input int i);
    case (i)
      0:  return 2949120;
      1:  return 1740967;
      2:  return 919879;
      3:  return 466945;
      4:  return 234379;
      5:  return 117304;
      6:  return 58666;
      7:  return 29335;
      8:  return 14668;
      9:  return 7334;
      10: return 3667;
      11: return 1833;
      12: return 917;
      13: return 458;
      14: return 229;
      15: return 115;
      16: return 57;
      17: return 29;
      18: return 14;
      19: return 7;
      20: return 4;
      21: return 2;
      22: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic prb_out_t predict_polar(input logic [COORD_BITS-1:0] xp,
                                             input logic [COORD_BITS-1:0] yp,
                                             input logic [CFG_BITS-1:0]   fw,
                                             input logic [CFG_BITS-1:0]   fh);
    longint hx, hy, xv, yv, dx, dy, adx, ady;
    longint cx, cy, cz, xs, ys, bearing;
    longint unsigned sq, rem, root, probe;
    prb_out_t o;
    hx = longint'(fw[CFG_BITS-1:1]);
    hy = longint'(fh);
    xv = longint'(xp);
    yv = longint'(yp);
    dx = hx - xv;
    dy = hy - yv;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;

    // Range: integer square root of 256 * (dx^2 + dy^2), round to nearest
    sq = (adx * adx + ady * ady) * 256;
    rem = sq;
    root = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    if (sq - root * root > root) root = root + 1;
    if (root > longint'(RANGE_MAX)) root = longint'(RANGE_MAX);

    // Bearing: vectoring rotations on |dy| (x axis) and |dx| (y axis)
    bearing = 0;
    if (adx != 0) begin
      cx = ady * 65536;
      cy = adx * 65536;
      cz = 0;
      for (int i = 0; i < STAGES && i < TABLE_LEN; i++) begin
        xs = cx >>> i;
        ys = cy >>> i;
        if (cy > 0) begin
          cx = cx + ys;
          cy = cy - xs;
          cz = cz + atan_step_q16(i);
        end else begin
          cx = cx - ys;
          cy = cy + xs;
          cz = cz - atan_step_q16(i);
        end
      end
      bearing = (cz + 128) >>> 8;
      if (bearing < 0) bearing = 0;
      if (bearing > BEARING_LIMIT) bearing = BEARING_LIMIT;
      if (dx < 0) bearing = -bearing;
    end

    o.range_fixed     = root[RANGE_BITS-1:0];
    o.bearing_degrees = bearing[ANGLE_BITS-1:0];
    o.zero_range      = (adx == 0 && ady == 0);
    return o;
  endfunction

  always @(posedge clk) begin : watch
    int bad;
    prb_out_t want;
    if (rst) begin
      frame_w = IMG_WIDTH_RST;
      frame_h = IMG_HEIGHT_RST;
      polar_q.delete();
      n_issued  <= 0;
      n_checked <= 0;
    end else begin
      bad = 0;
      if (done) begin
        if (polar_q.size() == 0) begin
          $error("unexpected result: range_fixed %0d bearing_degrees %0d zero_range %0d",
                 result.range_fixed, $signed(result.bearing_degrees), result.zero_range);
          bad++;
        end else begin
          want = polar_q.pop_front();
          if (result.range_fixed !== want.range_fixed) begin
            $error("range_fixed: expected %0d, got %0d", want.range_fixed,
                   result.range_fixed);
            bad++;
          end
          if (result.bearing_degrees !== want.bearing_degrees) begin
            $error("bearing_degrees: expected %0d, got %0d",
                   $signed(want.bearing_degrees), $signed(result.bearing_degrees));
            bad++;
          end
          if (result.zero_range !== want.zero_range) begin
            $error("zero_range: expected %0d, got %0d", want.zero_range,
                   result.zero_range);
            bad++;
          end
          n_checked <= n_checked + 1;
        end
      end
      // a transaction taken on a write edge still sees the old registers
      if (start && !busy) begin
        polar_q.push_back(predict_polar(item.x_pixel, item.y_pixel, frame_w, frame_h));
        n_issued <= n_issued + 1;
      end
      if (cfg_we) begin
        if (cfg_index == REG_IMG_WIDTH) frame_w = cfg_data;
        else if (cfg_index == REG_IMG_HEIGHT) frame_h = cfg_data;
      end
      if (bad != 0) n_err <= n_err + unsigned'(bad);
    end
  end

endmodule

>>> sim/tb_pixel_range_and_bearing_top.sv
// Testbench top for the pixel range and bearing block: clock, reset, command
// and configuration stimulus, watchdog and verdict.
// Depends on prb_pkg, pixel_range_and_bearing_top and prb_polar_checker.
`timescale 1ns / 1ps

module tb_pixel_range_and_bearing_top;
  import prb_pkg::*;

  localparam int LATENCY =
    ((CORDIC_STAGES_DEF > 18) ? CORDIC_STAGES_DEF : 18) + 4;
  localparam int N_PHASES       = 9;
  localparam int ITEMS_PER_PHASE = 135;
  // Cycles with no transaction on either side before the run is abandoned
  localparam int STALL_LIMIT    = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      start = 1'b0;
  logic                      busy;
  prb_in_t                   item = '0;
  logic                      done;
  prb_out_t                  result;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_IMG_WIDTH;
  logic [CFG_BITS-1:0]       cfg_data = '0;

  int unsigned pending;
  int unsigned checked;
  int unsigned err_count;
  int unsigned items_sent = 0;
  int unsigned stall_cycles = 0;

  always #5 clk = ~clk;

  pixel_range_and_bearing_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  prb_polar_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .checked   (checked),
    .err_count (err_count)
  );

  // Watchdog: any accepted command or shown result restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_pixel_range_and_bearing_top NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > 4095) return 12'd4095;
    return v[COORD_BITS-1:0];
  endfunction

  // One command transaction. Before it, the sender idles with a chance of
  // idle_pct percent per cycle. start stays high across back-to-back items.
  task automatic send_point(input int x, input int y, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    item.x_pixel <= clamp_coord(x);
    item.y_pixel <= clamp_coord(y);
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // Random point, weighted toward the geometry that matters: the reference
  // point, its column (dx zero), its row (dy zero) and its neighborhood.
  task automatic send_random_point(input int ref_x, input int ref_y, input int idle_pct);
    int mode;
    mode = $urandom_range(9);
    case (mode)
      5, 6: send_point(ref_x + $urandom_range(30) - 15, ref_y + $urandom_range(30) - 15,
                       idle_pct);
      7: send_point(ref_x, $urandom_range(4095), idle_pct);
      8: send_point($urandom_range(4095), ref_y, idle_pct);
      9: send_point(ref_x, ref_y, idle_pct);
      default: send_point($urandom_range(4095), $urandom_range(4095), idle_pct);
    endcase
  endtask

  // Registers change only with nothing in flight: drain, pad by the
  // latency, then write both frame registers back to back.
  task automatic set_frame(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_IMG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CFG_BITS-1:0] fw, fh;
    int ref_x, ref_y, idle_pct;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed points under the reset frame (640 x 480, reference 320, 480):
    // the reference itself, frame corners, straight ahead and behind,
    // level left and right, and the neighbors of the reference.
    send_point(320, 480, 0);
    send_point(0, 0, 0);
    send_point(4095, 4095, 0);
    send_point(320, 0, 0);
    send_point(320, 4095, 0);
    send_point(0, 480, 0);
    send_point(640, 480, 0);
    send_point(4095, 0, 0);
    send_point(0, 4095, 0);
    send_point(319, 479, 0);
    send_point(321, 481, 0);
    send_point(321, 479, 0);
    send_point(4095, 480, 0);
    send_point(0, 481, 0);

    fw = IMG_WIDTH_RST;
    fh = IMG_HEIGHT_RST;
    for (int phase = 0; phase < N_PHASES; phase++) begin
      // Frame settings: minimum, nominal maximum, 1280 x 720, zero, full
      // register width (range saturates), mixed, random and back to default.
      case (phase)
        1: begin fw = 13'd1;    fh = 13'd1;    end
        2: begin fw = 13'd4096; fh = 13'd4096; end
        3: begin fw = 13'd1280; fh = 13'd720;  end
        4: begin fw = 13'd0;    fh = 13'd0;    end
        5: begin fw = 13'd8191; fh = 13'd8191; end
        6: begin fw = 13'd4095; fh = 13'd1;    end
        7: begin
          fw = CFG_BITS'($urandom_range(4096, 1));
          fh = CFG_BITS'($urandom_range(4096, 1));
        end
        8: begin fw = IMG_WIDTH_RST; fh = IMG_HEIGHT_RST; end
        default: ;
      endcase
      if (phase != 0) set_frame(fw, fh);
      ref_x = int'(fw >> 1);
      ref_y = int'(fh);
      // Sender idling cycles through none, heavy and moderate.
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 46;
        default: idle_pct = 35;
      endcase

      // Corners of each setting: reference, origin, far corner, axis ends
      send_point(ref_x, ref_y, idle_pct);
      send_point(0, 0, idle_pct);
      send_point(4095, 4095, idle_pct);
      send_point(ref_x, 0, idle_pct);
      send_point(0, ref_y, idle_pct);

      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        send_random_point(ref_x, ref_y, idle_pct);
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("covered %0d transactions over %0d frame settings, %0d results checked",
             items_sent, N_PHASES, checked);
    $display("frames from 0 x 0 to 8191 x 8191, idle rates 0, 35 and 46 percent");
    if (err_count == 0) begin
      $display("tb_pixel_range_and_bearing_top OK");
    end else begin
      $display("tb_pixel_range_and_bearing_top NOT OK");
    end
    $finish;
  end

endmodule

>>> pixel_range_and_bearing_top.f
hdl/prb_pkg.sv
hdl/prb_iter_stage.sv
hdl/pixel_range_and_bearing_top.sv
sim/prb_polar_checker.sv
sim/tb_pixel_range_and_bearing_top.sv
